>>> rtl/gn2d_pkg.sv
`timescale 1ns / 1ps
package gn2d_pkg;
  localparam int FracBits = 16;
  localparam int MaxShift = 8;
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;
  localparam logic [3:0] ShiftReset = 4'd4;

  typedef logic signed [FracBits+5:0] fx_t;

  typedef struct packed {
    logic       valid;
    logic       wr;
    logic [7:0] addr;
    logic [7:0] data;
  } tbl_req_t;

  function automatic fx_t fx_mul(fx_t a, fx_t b);
    logic signed [2*(FracBits+6)-1:0] p;
    p = a * b + (1 <<< (FracBits - 1));
    return fx_t'(p >>> FracBits);
  endfunction

  function automatic fx_t corner(logic [1:0] h, fx_t dx, fx_t dy);
    fx_t u;
    fx_t v;
    fx_t pu;
    fx_t pv;
    u  = h[1] ? dy : dx;
    v  = h[1] ? dx : dy;
    pu = h[0] ? -u : u;
    pv = h[1] ? -(v <<< 1) : (v <<< 1);
    return pu + pv;
  endfunction
endpackage

>>> rtl/gradient_noise_2d.sv
`timescale 1ns / 1ps
// Gradient noise: one transaction per clock, busy_o is always low and the receiver cannot
// stall, so every result must be taken in the cycle that result_valid_o marks. A table load
// writes the permutation memory and gives no result; an evaluation gives noise_o with
// result_valid_o high for one cycle. Its path runs through the two dependent reads of the
// permutation memory, the hash registers h_a_q..hd_q and then ra3_q..rd3_q, the corner gradients
// and the two blend stages. A load accepted after an evaluation never affects that
// evaluation, and an evaluation sees every load accepted before it.
module gradient_noise_2d import gn2d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cmd_i,
  input  logic [7:0]         table_index_i,
  input  logic [7:0]         table_value_i,
  input  logic [15:0]        column_i,
  input  logic [15:0]        row_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_data_i,
  output logic               result_valid_o,
  output logic signed [18:0] noise_o
);
  localparam fx_t One = fx_t'(1) <<< FracBits;
  logic [3:0] shift_q;
  logic [3:0] s;
  tbl_req_t wr;
  logic [7:0] cy0_q;
  logic [7:0] qa, qb, ra, rb;
  logic [7:0] ha, hb, hc, hd;
  logic [7:0] h_a_q, h_b_q, hc_q, hd_q;
  logic [7:0] ra3_q, rb3_q, rc3_q, rd3_q;
  logic [6:0] v_q;
  fx_t fx, fy, u, v;
  fx_t fx_p [4];
  fx_t fy_p [4];
  fx_t g1_q, g2_q, g3_q, g4_q, u5_q, u6_q, v5_q, v6_q, v7_q;
  fx_t l1_q, l2_q, r_q;
  logic [15:0] col, row;
  fx_t res;
  logic unused;

  assign busy_o = 1'b0;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= ShiftReset;
    end else if (cfg_valid_i) begin
      shift_q <= cfg_data_i;
    end
  end
  assign s = (shift_q > 4'(MaxShift)) ? 4'(MaxShift) : shift_q;
  assign col = column_i >> s;
  assign row = row_i >> s;
  assign fx = fx_t'((column_i & ((16'd1 << s) - 16'd1))) <<< (FracBits - int'(s));
  assign fy = fx_t'((row_i & ((16'd1 << s) - 16'd1))) <<< (FracBits - int'(s));

  assign wr.valid = start_i & (cmd_i == CmdLoad);
  assign wr.wr    = wr.valid;
  assign wr.addr  = table_index_i;
  assign wr.data  = table_value_i;

  // Stage 1 reads cx and cx+1, stage 2 reads four hashes (two ports; reading them in turn
  // would stall), so a further memory copy serves the second pair.
  assign ra = qa + cy0_q;
  assign rb = qb + cy0_q;
  gn2d_ram u_ram_a (.clk_i, .we_i(wr.wr), .waddr_i(wr.addr), .wdata_i(wr.data),
    .raddr_a_i(col[7:0]), .raddr_b_i(col[7:0] + 8'd1), .rdata_a_o(qa), .rdata_b_o(qb));
  gn2d_ram u_ram_b (.clk_i, .we_i(wr.wr), .waddr_i(wr.addr), .wdata_i(wr.data),
    .raddr_a_i(ra), .raddr_b_i(rb), .rdata_a_o(ha), .rdata_b_o(hb));
  gn2d_ram u_ram_c (.clk_i, .we_i(wr.wr), .waddr_i(wr.addr), .wdata_i(wr.data),
    .raddr_a_i(ra + 8'd1), .raddr_b_i(rb + 8'd1), .rdata_a_o(hc), .rdata_b_o(hd));

  always_ff @(posedge clk_i) begin
    cy0_q <= row[7:0];
    h_a_q <= ha;
    h_b_q <= hb;
    hc_q  <= hc;
    hd_q  <= hd;
    ra3_q <= h_a_q;
    rb3_q <= h_b_q;
    rc3_q <= hc_q;
    rd3_q <= hd_q;
  end

  gn2d_fade u_fx (.clk_i, .t_i(fx), .s_o(u));
  gn2d_fade u_fy (.clk_i, .t_i(fy), .s_o(v));

  always_ff @(posedge clk_i) begin
    fx_p[0] <= fx; fy_p[0] <= fy;
    for (int i = 1; i < 4; i++) begin
      fx_p[i] <= fx_p[i-1]; fy_p[i] <= fy_p[i-1];
    end
    g1_q <= corner(ra3_q[1:0], fx_p[3], fy_p[3]);
    g2_q <= corner(rb3_q[1:0], fx_p[3] - One, fy_p[3]);
    g3_q <= corner(rc3_q[1:0], fx_p[3], fy_p[3] - One);
    g4_q <= corner(rd3_q[1:0], fx_p[3] - One, fy_p[3] - One);
    u5_q <= u; u6_q <= u5_q;
    v5_q <= v; v6_q <= v5_q; v7_q <= v6_q;
    l1_q <= g1_q + fx_mul(u6_q, g2_q - g1_q);
    l2_q <= g3_q + fx_mul(u6_q, g4_q - g3_q);
    r_q  <= l1_q + fx_mul(v7_q, l2_q - l1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:0], start_i & (cmd_i == CmdEval)};
    end
  end
  assign res = (r_q + One + fx_t'(1)) >>> 1;
  assign result_valid_o = v_q[6];
  assign noise_o = res[18:0];
  assign unused = ^{col[15:8], row[15:8]};
endmodule

>>> rtl/gn2d_ram.sv
`timescale 1ns / 1ps
module gn2d_ram (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic [7:0] raddr_a_i,
  input  logic [7:0] raddr_b_i,
  output logic [7:0] rdata_a_o,
  output logic [7:0] rdata_b_o
);
  logic [7:0] mem [256];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end
endmodule

>>> rtl/gn2d_fade.sv
`timescale 1ns / 1ps
module gn2d_fade import gn2d_pkg::*; (
  input  logic clk_i,
  input  fx_t  t_i,
  output fx_t  s_o
);
  localparam fx_t One = fx_t'(1) <<< FracBits;
  fx_t t1_q, tt_q, p1_q, t3_q, p2_q, s_q;

  always_ff @(posedge clk_i) begin
    t1_q <= t_i;
    tt_q <= fx_mul(t_i, t_i);
    p1_q <= fx_mul(t_i, fx_t'(6) * t_i - fx_t'(15) * One);
    t3_q <= fx_mul(tt_q, t1_q);
    p2_q <= p1_q + fx_t'(10) * One;
    s_q  <= fx_mul(t3_q, p2_q);
  end
  assign s_o = s_q;
endmodule

>>> rtl/gn2d_checker.sv
`timescale 1ns / 1ps
module gn2d_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic cmd_i,
  input logic busy_o,
  input logic result_valid_o
);
  a_nobusy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !cmd_i) |-> ##7 !result_valid_o)
    else $error("load produced result");
  a_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && cmd_i) |-> ##7 result_valid_o)
    else $error("missing result");
endmodule

bind gradient_noise_2d gn2d_checker u_chk (.*);
